### hw/rtl/dtp_pkg.sv
// Shared types and constants for the DER TLV stream parser.
// No dependencies; imported by dtp_core and der_tlv_stream_parser.
package dtp_pkg;

	// Status codes reported with each result
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TRUNCATED = 2'd1,
		ST_LEN_LONG  = 2'd2,
		ST_INDEF     = 2'd3
	} status_t;

	// Identifier octet fields
	localparam logic [1:0] CLASS_UNIVERSAL = 2'd0;
	localparam logic [4:0] TAG_INTEGER     = 5'h02;
	localparam logic [4:0] TAG_OCTET_STR   = 5'h04;
	localparam logic [4:0] TAG_IA5_STR     = 5'h16;

	// One result transaction
	typedef struct packed {
		logic [7:0]         content_byte;
		logic               content_valid;
		logic               header_done;
		logic               element_done;
		logic [1:0]         tag_class;
		logic               is_constructed;
		logic [4:0]         tag_number;
		logic [31:0]        content_length;
		logic signed [31:0] int_value;
		logic               int_ok;
		logic               is_string;
		status_t            status;
	} result_t;

endpackage

### hw/rtl/der_tlv_stream_parser.sv
// DER TLV stream parser: one byte per transaction in, one result per byte out.
// Result path: input register, then result register; either holds its byte while the sink stalls.
// Throughput: one byte per cycle while out_ready is high; the combinational decode step sets the rate.
// Reset: arst_n asynchronous, active low; parser returns to expecting an identifier
// octet with all held fields zero and both pipeline stages empty.
// Top level: input register stage feeding dtp_core; depends on dtp_pkg and dtp_core.
module der_tlv_stream_parser import dtp_pkg::*; #(
	parameter int MAX_LENGTH_OCTETS = 4,
	parameter int MAX_INT_BYTES     = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_byte,
	input  logic               buffer_end,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         content_byte,
	output logic               content_valid,
	output logic               header_done,
	output logic               element_done,
	output logic [1:0]         tag_class,
	output logic               is_constructed,
	output logic [4:0]         tag_number,
	output logic [31:0]        content_length,
	output logic signed [31:0] int_value,
	output logic               int_ok,
	output logic               is_string,
	output logic [1:0]         status
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       core_ready;
	logic       take;
	result_t    res;

	assign take     = valid_s1 && core_ready;
	assign in_ready = !valid_s1 || core_ready;

	// Input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= buffer_end;
		end
	end

	dtp_core #(
		.MAX_LENGTH_OCTETS (MAX_LENGTH_OCTETS),
		.MAX_INT_BYTES     (MAX_INT_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.byte_in    (byte_s1),
		.last_in    (last_s1),
		.take_ready (core_ready),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	// Result fields
	assign content_byte   = res.content_byte;
	assign content_valid  = res.content_valid;
	assign header_done    = res.header_done;
	assign element_done   = res.element_done;
	assign tag_class      = res.tag_class;
	assign is_constructed = res.is_constructed;
	assign tag_number     = res.tag_number;
	assign content_length = res.content_length;
	assign int_value      = res.int_value;
	assign int_ok         = res.int_ok;
	assign is_string      = res.is_string;
	assign status         = res.status;

endmodule

### hw/rtl/dtp_core.sv
// Parse state, per-byte decode step and result register of the DER parser.
// Depends on dtp_pkg.
module dtp_core import dtp_pkg::*; #(
	parameter int MAX_LENGTH_OCTETS = 4,
	parameter int MAX_INT_BYTES     = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	output logic       take_ready,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    res
);

	localparam int CntW = $clog2(MAX_LENGTH_OCTETS + 1);

	typedef enum logic [2:0] {
		PH_IDENT     = 3'd0,
		PH_LEN_FIRST = 3'd1,
		PH_LEN_MORE  = 3'd2,
		PH_CONTENT   = 3'd3,
		PH_SKIP      = 3'd4
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [1:0]        class_q, class_d;
	logic              cons_q, cons_d;
	logic [4:0]        tag_q, tag_d;
	logic [CntW-1:0]   oct_left_q, oct_left_d;
	logic [31:0]       len_q, len_d;
	logic [31:0]       cbl_q, cbl_d;
	logic [31:0]       iacc_q, iacc_d;
	logic              res_valid_q;
	result_t           res_q, res_d;
	logic [6:0]        n_oct;
	logic              cvalid, hdr, edone;
	status_t           status;

	assign take_ready = !res_valid_q || res_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign n_oct      = byte_in[6:0];

	// Decode step for one byte
	always_comb begin
		phase_d    = phase_q;
		class_d    = class_q;
		cons_d     = cons_q;
		tag_d      = tag_q;
		oct_left_d = oct_left_q;
		len_d      = len_q;
		cbl_d      = cbl_q;
		iacc_d     = iacc_q;
		cvalid     = 1'b0;
		hdr        = 1'b0;
		edone      = 1'b0;
		status     = ST_OK;

		unique case (phase_q)
			PH_IDENT: begin
				class_d    = byte_in[7:6];
				cons_d     = byte_in[5];
				tag_d      = byte_in[4:0];
				len_d      = '0;
				oct_left_d = '0;
				cbl_d      = '0;
				iacc_d     = '0;
				phase_d    = PH_LEN_FIRST;
			end
			PH_LEN_FIRST: begin
				if (byte_in[7]) begin
					if (n_oct == 7'd0) begin
						status  = ST_INDEF;
						phase_d = PH_SKIP;
					end else if (int'(n_oct) > MAX_LENGTH_OCTETS) begin
						status  = ST_LEN_LONG;
						phase_d = PH_SKIP;
					end else begin
						oct_left_d = CntW'(n_oct);
						len_d      = '0;
						phase_d    = PH_LEN_MORE;
					end
				end else begin
					len_d = {24'd0, byte_in};
					hdr   = 1'b1;
				end
			end
			PH_LEN_MORE: begin
				len_d = {len_q[23:0], byte_in};
				if (oct_left_q != '0)
					oct_left_d = oct_left_q - CntW'(1);
				if (oct_left_d == '0)
					hdr = 1'b1;
			end
			PH_CONTENT: begin
				cvalid = 1'b1;
				iacc_d = {iacc_q[23:0], byte_in};
				// first content byte with the sign bit set: sign extend
				if (cbl_q == len_q && byte_in[7])
					iacc_d = {24'hffffff, byte_in};
				if (cbl_q != '0)
					cbl_d = cbl_q - 32'd1;
				if (cbl_d == '0) begin
					edone   = 1'b1;
					phase_d = PH_IDENT;
				end
			end
			default: begin
				phase_d = PH_SKIP;
			end
		endcase

		// Header complete: empty or constructed elements go back to identifier, others to content
		if (hdr) begin
			iacc_d = '0;
			if (cons_d || len_d == '0) begin
				edone   = !cons_d;
				phase_d = PH_IDENT;
			end else begin
				cbl_d   = len_d;
				phase_d = PH_CONTENT;
			end
		end

		// End of buffer
		if (last_in) begin
			if (status == ST_OK && phase_d != PH_IDENT && phase_d != PH_SKIP)
				status = ST_TRUNCATED;
			phase_d = PH_IDENT;
		end

		res_d.content_byte   = cvalid ? byte_in : 8'd0;
		res_d.content_valid  = cvalid;
		res_d.header_done    = hdr;
		res_d.element_done   = edone;
		res_d.tag_class      = class_d;
		res_d.is_constructed = cons_d;
		res_d.tag_number     = tag_d;
		res_d.content_length = len_d;
		res_d.int_value      = edone ? signed'(iacc_d) : 32'sd0;
		res_d.int_ok         = edone && class_d == CLASS_UNIVERSAL && tag_d == TAG_INTEGER
			&& len_d <= 32'(MAX_INT_BYTES);
		res_d.is_string      = (tag_d == TAG_OCTET_STR) || (tag_d == TAG_IA5_STR);
		res_d.status         = status;
	end

	// State and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDENT;
			class_q     <= '0;
			cons_q      <= 1'b0;
			tag_q       <= '0;
			oct_left_q  <= '0;
			len_q       <= '0;
			cbl_q       <= '0;
			iacc_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take_ready)
				res_valid_q <= take;
			if (take) begin
				phase_q    <= phase_d;
				class_q    <= class_d;
				cons_q     <= cons_d;
				tag_q      <= tag_d;
				oct_left_q <= oct_left_d;
				len_q      <= len_d;
				cbl_q      <= cbl_d;
				iacc_q     <= iacc_d;
			end
		end
	end

	// Result payload, no reset needed
	always_ff @(posedge clk) begin
		if (take)
			res_q <= res_d;
	end

`ifndef SYNTHESIS
	// int_ok only comes with a finished element
	a_int_ok_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.int_ok |-> res_q.element_done)
		else $error("int_ok without element_done");

	// a content byte never completes a header
	a_content_not_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.content_valid |-> !res_q.header_done)
		else $error("content byte flagged as header");

	// long-form length phase always has octets pending
	a_len_more_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEN_MORE |-> oct_left_q != '0)
		else $error("length phase with no octets left");

	// buffer end always lands back at identifier
	a_last_ident: assert property (@(posedge clk) disable iff (!arst_n)
		take && last_in |=> phase_q == PH_IDENT)
		else $error("buffer end did not reset parse phase");

	// a result waiting on a stalled sink holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |=> res_valid_q && $stable(res_q))
		else $error("stalled result changed");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for der_tlv_stream_parser: directed and random DER buffers.
// Depends on dtp_pkg and the parser RTL; holds its own byte-level decoder to predict each result.
`timescale 1ns / 1ps

module tb;
	import dtp_pkg::*;

	localparam int MAX_LENGTH_OCTETS = 4;
	localparam int MAX_INT_BYTES     = 4;

	// Decoder phases of the predictor
	typedef enum logic [2:0] {
		P_IDENT     = 3'd0,
		P_LEN_FIRST = 3'd1,
		P_LEN_MORE  = 3'd2,
		P_CONTENT   = 3'd3,
		P_SKIP      = 3'd4
	} phase_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         in_byte = 8'h00;
	logic               buffer_end = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         content_byte;
	logic               content_valid;
	logic               header_done;
	logic               element_done;
	logic [1:0]         tag_class;
	logic               is_constructed;
	logic [4:0]         tag_number;
	logic [31:0]        content_length;
	logic signed [31:0] int_value;
	logic               int_ok;
	logic               is_string;
	logic [1:0]         status;

	// Predictor state
	phase_t      dec_phase = P_IDENT;
	logic [1:0]  dec_class = '0;
	logic        dec_cons = 1'b0;
	logic [4:0]  dec_tag = '0;
	logic [2:0]  dec_len_left = '0;
	logic [31:0] dec_len_acc = '0;
	logic [31:0] dec_cnt_left = '0;
	logic [31:0] dec_int_acc = '0;

	result_t     expected_tlv_q[$];
	logic [7:0]  frame_q[$];
	int          mismatch_count = 0;
	int          bytes_sent = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;

	der_tlv_stream_parser #(
		.MAX_LENGTH_OCTETS(MAX_LENGTH_OCTETS),
		.MAX_INT_BYTES(MAX_INT_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.buffer_end(buffer_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.content_byte(content_byte),
		.content_valid(content_valid),
		.header_done(header_done),
		.element_done(element_done),
		.tag_class(tag_class),
		.is_constructed(is_constructed),
		.tag_number(tag_number),
		.content_length(content_length),
		.int_value(int_value),
		.int_ok(int_ok),
		.is_string(is_string),
		.status(status)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop in case the parser hangs
	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

	// Length known: primitive content follows, or back to identifier
	function automatic void close_header(inout logic hdr, inout logic edone);
		hdr = 1'b1;
		dec_int_acc = '0;
		if (dec_cons || dec_len_acc == 0) begin
			if (!dec_cons)
				edone = 1'b1;
			dec_phase = P_IDENT;
		end else begin
			dec_cnt_left = dec_len_acc;
			dec_phase = P_CONTENT;
		end
	endfunction

	// Advance the predictor by one byte and return the expected result
	function automatic result_t decode_byte(input logic [7:0] b, input logic last);
		result_t r;
		logic    hdr;
		logic    edone;
		logic    cvalid;
		logic [6:0] n;
		status_t st;
		hdr = 1'b0;
		edone = 1'b0;
		cvalid = 1'b0;
		st = ST_OK;
		r = '0;
		case (dec_phase)
			P_IDENT: begin
				dec_class = b[7:6];
				dec_cons = b[5];
				dec_tag = b[4:0];
				dec_len_acc = '0;
				dec_len_left = '0;
				dec_cnt_left = '0;
				dec_int_acc = '0;
				dec_phase = P_LEN_FIRST;
			end
			P_LEN_FIRST: begin
				if (b[7]) begin
					n = b[6:0];
					if (n == 0) begin
						st = ST_INDEF;
						dec_phase = P_SKIP;
					end else if (n > MAX_LENGTH_OCTETS) begin
						st = ST_LEN_LONG;
						dec_phase = P_SKIP;
					end else begin
						dec_len_left = 3'(n);
						dec_len_acc = '0;
						dec_phase = P_LEN_MORE;
					end
				end else begin
					dec_len_acc = {24'h0, b};
					close_header(hdr, edone);
				end
			end
			P_LEN_MORE: begin
				dec_len_acc = {dec_len_acc[23:0], b};
				if (dec_len_left > 0)
					dec_len_left = dec_len_left - 3'd1;
				if (dec_len_left == 0)
					close_header(hdr, edone);
			end
			P_CONTENT: begin
				cvalid = 1'b1;
				r.content_byte = b;
				// first content byte with the sign bit set fills with ones
				if (dec_cnt_left == dec_len_acc && b[7])
					dec_int_acc = '1;
				dec_int_acc = {dec_int_acc[23:0], b};
				if (dec_cnt_left > 0)
					dec_cnt_left = dec_cnt_left - 32'd1;
				if (dec_cnt_left == 0) begin
					edone = 1'b1;
					dec_phase = P_IDENT;
				end
			end
			default: dec_phase = P_SKIP;
		endcase
		if (last) begin
			if (st == ST_OK && dec_phase != P_IDENT && dec_phase != P_SKIP)
				st = ST_TRUNCATED;
			dec_phase = P_IDENT;
		end
		r.content_valid = cvalid;
		r.header_done = hdr;
		r.element_done = edone;
		r.tag_class = dec_class;
		r.is_constructed = dec_cons;
		r.tag_number = dec_tag;
		r.content_length = dec_len_acc;
		r.int_value = edone ? dec_int_acc : 32'sd0;
		r.int_ok = edone && dec_class == CLASS_UNIVERSAL && dec_tag == TAG_INTEGER &&
			dec_len_acc <= MAX_INT_BYTES;
		r.is_string = (dec_tag == TAG_OCTET_STR || dec_tag == TAG_IA5_STR);
		r.status = st;
		return r;
	endfunction

	// Send one byte; in_valid is only lowered while idling
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		buffer_end <= last;
		do @(posedge clk); while (!in_ready);
		expected_tlv_q.push_back(decode_byte(b, last));
		bytes_sent++;
	endtask

	// Send frame_q as one buffer, buffer_end on its final byte
	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	// Hold off the sender until every result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_tlv_q.size() != 0);
	endtask

	// Length octets: short form or long form with optional leading zeros
	function automatic void append_length(input logic [31:0] len, input bit force_long);
		int nmin;
		int n;
		if (len < 128 && !force_long) begin
			frame_q.push_back(len[7:0]);
		end else begin
			nmin = (len > 32'hffffff) ? 4 : (len > 32'hffff) ? 3 : (len > 32'hff) ? 2 : 1;
			n = nmin + $urandom_range(4 - nmin);
			frame_q.push_back(8'h80 | 8'(n));
			for (int i = n - 1; i >= 0; i--)
				frame_q.push_back(8'(len >> (8 * i)));
		end
	endfunction

	// One well-formed element with random identifier and content
	function automatic void append_element();
		logic [1:0]  cls;
		logic        cons;
		logic [4:0]  tag;
		logic [31:0] len;
		case ($urandom_range(4))
			0: tag = TAG_INTEGER;
			1: tag = TAG_OCTET_STR;
			2: tag = TAG_IA5_STR;
			default: tag = 5'($urandom_range(31));
		endcase
		cls = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : CLASS_UNIVERSAL;
		cons = ($urandom_range(7) == 0);
		if (tag == TAG_INTEGER)
			len = $urandom_range(6);
		else
			len = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(6);
		frame_q.push_back({cls, cons, tag});
		append_length(len, $urandom_range(3) == 0);
		if (!cons)
			for (int i = 0; i < len; i++)
				frame_q.push_back(8'($urandom_range(255)));
	endfunction

	// Random buffer: mostly well-formed, some truncated, erroneous or noise
	function automatic void build_frame();
		int sel;
		int start;
		int n;
		frame_q.delete();
		sel = $urandom_range(99);
		if (sel < 78) begin
			n = $urandom_range(1, 4);
			repeat (n) append_element();
		end else if (sel < 88) begin
			repeat ($urandom_range(2)) append_element();
			if ($urandom_range(2) == 0) begin
				// huge long-form length, cut before the content ends
				frame_q.push_back(8'($urandom_range(255)) & 8'hdf);
				append_length($urandom, 1'b1);
				repeat ($urandom_range(3)) frame_q.push_back(8'($urandom_range(255)));
			end else begin
				start = frame_q.size();
				append_element();
				if (frame_q.size() - start > 1) begin
					n = $urandom_range(start + 1, frame_q.size() - 1);
					while (frame_q.size() > n)
						void'(frame_q.pop_back());
				end
			end
		end else if (sel < 95) begin
			repeat ($urandom_range(1)) append_element();
			frame_q.push_back(8'($urandom_range(255)));
			if ($urandom_range(1) == 0)
				frame_q.push_back(8'h80);
			else
				frame_q.push_back(8'h80 | 8'($urandom_range(MAX_LENGTH_OCTETS + 1, 127)));
			repeat ($urandom_range(3)) frame_q.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(255)));
		end
	endfunction

	task automatic report_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Result side: random back-pressure and field-by-field check
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_tlv_q.size() == 0) begin
				$display("%0t: result transaction with nothing expected, expected none actual %h",
					$time, content_byte);
				mismatch_count++;
			end else begin
				exp_r = expected_tlv_q.pop_front();
				report_field("content_byte", 32'(exp_r.content_byte), 32'(content_byte));
				report_field("content_valid", 32'(exp_r.content_valid), 32'(content_valid));
				report_field("header_done", 32'(exp_r.header_done), 32'(header_done));
				report_field("element_done", 32'(exp_r.element_done), 32'(element_done));
				report_field("tag_class", 32'(exp_r.tag_class), 32'(tag_class));
				report_field("is_constructed", 32'(exp_r.is_constructed),
					32'(is_constructed));
				report_field("tag_number", 32'(exp_r.tag_number), 32'(tag_number));
				report_field("content_length", exp_r.content_length, content_length);
				report_field("int_value", 32'(exp_r.int_value), 32'(int_value));
				report_field("int_ok", 32'(exp_r.int_ok), 32'(int_ok));
				report_field("is_string", 32'(exp_r.is_string), 32'(is_string));
				report_field("status", 32'(exp_r.status), 32'(status));
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sign extension, empty primitive, nested constructed, error codes, truncation
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		frame_q = '{8'h02, 8'h01, 8'h80, 8'h04, 8'h00, 8'h30, 8'h03, 8'h02, 8'h01, 8'h7f};
		send_frame();
		// indefinite length, then a skipped byte ends the buffer
		frame_q = '{8'hff, 8'h80, 8'h00};
		send_frame();
		// length over limit on the byte that carries buffer_end
		frame_q = '{8'hc2, 8'h85};
		send_frame();
		// long-form IA5 string cut short
		frame_q = '{8'h16, 8'h81, 8'h02, 8'h41};
		send_frame();
		// all-ones length, truncated right after the header
		frame_q = '{8'h02, 8'h84, 8'hff, 8'hff, 8'hff, 8'hff};
		send_frame();
	endtask

	task automatic test_random(input int s_pct, input int r_pct, input int count);
		int target;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		target = bytes_sent + count;
		while (bytes_sent < target) begin
			build_frame();
			send_frame();
			if ($urandom_range(49) == 0)
				wait_drained();
		end
	endtask

	// Sender holds off until the pipeline is empty, then resumes
	task automatic test_drain_pause();
		repeat (3) begin
			build_frame();
			send_frame();
		end
		wait_drained();
		build_frame();
		send_frame();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(6, 53, 540);
		test_random(53, 6, 540);
		test_drain_pause();
		test_random(0, 0, 540);
		in_valid <= 1'b0;
		while (expected_tlv_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_tlv_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
